FILE: rtl/core/wasq_pkg.sv
`timescale 1ns / 1ps
// shared types, constants and codes of the window autoscale quantizer
package wasq_pkg;

    // fixed field widths
    localparam int SAMPLE_W   = 16;
    localparam int LEVEL_W    = 8;
    localparam int POS_W      = 6;
    localparam int LEN_CFG_W  = 7;
    localparam int NUM_W      = SAMPLE_W + LEVEL_W;

    // stream and configuration port widths
    localparam int S_TDATA_W  = 16;
    localparam int M_TDATA_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // numeric constants
    localparam int UNIT_Q     = 4096;
    localparam logic signed [SAMPLE_W-1:0] UNIT_S = SAMPLE_W'(UNIT_Q);
    localparam int LEN_RESET  = 64;

    // sizes
    localparam int DEF_MAX_POINTS = 64;
    localparam int QDEPTH         = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_AUTOSCALE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILL      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LENGTH    = 2'd2;

    // action codes
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_CLEAR = 1'b1;

    typedef struct packed {
        logic                       autoscale_on;
        logic signed [SAMPLE_W-1:0] fill_value;
        logic [LEN_CFG_W-1:0]       window_length;
    } cfg_t;

    typedef struct packed {
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
    } item_t;

    typedef struct packed {
        logic                       autoscale;
        logic                       zero;
        logic signed [SAMPLE_W-1:0] lo;
        logic [SAMPLE_W-1:0]        divisor;
    } scale_t;

    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] x;
        logic [POS_W-1:0]           pos;
        logic                       last;
    } entry_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_UPDATE,
        ST_SCAN,
        ST_SCAN_TAIL,
        ST_SETUP,
        ST_EMIT,
        ST_DRAIN
    } back_state_t;

endpackage

FILE: rtl/core/wasq_front.sv
`timescale 1ns / 1ps
// front end: configuration registers, input acceptance and item queue
module wasq_front (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wasq_pkg::S_TDATA_W-1:0]    s_tdata,
    input  logic [0:0]                        s_tuser,
    input  logic                              cfg_wr_en,
    input  logic [wasq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wasq_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output wasq_pkg::cfg_t                    cfg,
    output logic                              q_valid,
    output wasq_pkg::item_t                   q_item,
    input  logic                              q_pop
);
    import wasq_pkg::*;

    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    logic                       autoscale_reg;
    logic signed [SAMPLE_W-1:0] fill_reg;
    logic [LEN_CFG_W-1:0]       length_reg;

    item_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   count_reg, count_next;
    logic                push;
    item_t               in_item;

    // configuration register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            autoscale_reg <= 1'b0;
            fill_reg      <= '0;
            length_reg    <= LEN_CFG_W'(LEN_RESET);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_AUTOSCALE: autoscale_reg <= cfg_wdata[0];
                REG_FILL:      fill_reg      <= cfg_wdata[SAMPLE_W-1:0];
                REG_LENGTH:    length_reg    <= cfg_wdata[LEN_CFG_W-1:0];
                default: ;
            endcase
        end
    end

    assign cfg.autoscale_on  = autoscale_reg;
    assign cfg.fill_value    = fill_reg;
    assign cfg.window_length = length_reg;

    // classify the incoming transfer into an item
    assign in_item.action = s_tuser[0];
    assign in_item.sample = (s_tuser[0] == ACT_CLEAR) ? '0 : s_tdata[SAMPLE_W-1:0];

    assign s_tready = (count_reg != QCNT_W'(QDEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign q_item   = q_mem[rd_ptr_reg];

    // queue pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (q_pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        case ({push, q_pop})
            2'b10:   count_next = count_reg + QCNT_W'(1);
            2'b01:   count_next = count_reg - QCNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // queue storage
    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_item;
        end
    end

endmodule

FILE: rtl/core/wasq_div.sv
`timescale 1ns / 1ps
// back end datapath: level numerator, pipelined restoring divider, output register
module wasq_div (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  wasq_pkg::entry_t                entry,
    input  wasq_pkg::scale_t                scale,
    output logic                            advance,
    output logic                            busy,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [wasq_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import wasq_pkg::*;

    localparam int NST = LEVEL_W + 1;
    localparam int PAD_W = M_TDATA_W - POS_W - LEVEL_W;

    logic                 v_reg    [NST];
    logic [NUM_W-1:0]     rem_reg  [NST];
    logic [NUM_W-1:0]     rem_next [NST];
    logic [LEVEL_W-1:0]   q_reg    [NST];
    logic [LEVEL_W-1:0]   q_next   [NST];
    logic [POS_W-1:0]     pos_reg  [NST];
    logic                 last_reg [NST];
    logic [NUM_W-1:0]     trial    [NST];

    logic signed [SAMPLE_W:0] diff_w;
    logic [SAMPLE_W-1:0]      base;
    logic [NUM_W-1:0]         num;

    // whole pipeline moves when the output register is free
    assign advance = !v_reg[LEVEL_W] || m_tready;

    // numerator: (x - lo) * 255 or clamp(x) * 255
    always_comb begin
        diff_w = {entry.x[SAMPLE_W-1], entry.x} - {scale.lo[SAMPLE_W-1], scale.lo};
        if (scale.autoscale) begin
            base = diff_w[SAMPLE_W-1:0];
        end else if (entry.x > UNIT_S) begin
            base = UNIT_S;
        end else if (entry.x < 0) begin
            base = '0;
        end else begin
            base = entry.x;
        end
        num = (NUM_W'(base) << LEVEL_W) - NUM_W'(base);
    end

    // one quotient bit per stage, most significant first
    always_comb begin
        rem_next[0] = num;
        q_next[0]   = '0;
        trial[0]    = '0;
        for (int s = 1; s < NST; s++) begin
            trial[s] = NUM_W'(scale.divisor) << (LEVEL_W - s);
            if (rem_reg[s-1] >= trial[s]) begin
                rem_next[s] = rem_reg[s-1] - trial[s];
                q_next[s]   = q_reg[s-1] | (LEVEL_W'(1) << (LEVEL_W - s));
            end else begin
                rem_next[s] = rem_reg[s-1];
                q_next[s]   = q_reg[s-1];
            end
        end
        if (scale.zero) begin
            q_next[LEVEL_W] = '0;
        end
    end

    // stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int s = 0; s < NST; s++) begin
                v_reg[s] <= 1'b0;
            end
        end else if (advance) begin
            v_reg[0] <= entry.valid;
            for (int s = 1; s < NST; s++) begin
                v_reg[s] <= v_reg[s-1];
            end
        end
    end

    // stage payload
    always_ff @(posedge aclk) begin
        if (advance) begin
            rem_reg[0]  <= rem_next[0];
            q_reg[0]    <= q_next[0];
            pos_reg[0]  <= entry.pos;
            last_reg[0] <= entry.last;
            for (int s = 1; s < NST; s++) begin
                rem_reg[s]  <= rem_next[s];
                q_reg[s]    <= q_next[s];
                pos_reg[s]  <= pos_reg[s-1];
                last_reg[s] <= last_reg[s-1];
            end
        end
    end

    // busy while any entry is short of the output register
    always_comb begin
        busy = 1'b0;
        for (int s = 0; s < LEVEL_W; s++) begin
            busy = busy | v_reg[s];
        end
    end

    assign m_tvalid = v_reg[LEVEL_W];
    assign m_tdata  = {PAD_W'(0), pos_reg[LEVEL_W], q_reg[LEVEL_W]};
    assign m_tlast  = last_reg[LEVEL_W];

endmodule

FILE: rtl/core/wasq_back.sv
`timescale 1ns / 1ps
// back end sequencer: window store, pointer upkeep, min/max scan and entry readout
module wasq_back #(
    parameter int MAX_POINTS = wasq_pkg::DEF_MAX_POINTS
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  wasq_pkg::cfg_t     cfg,
    input  logic               q_valid,
    input  wasq_pkg::item_t    q_item,
    output logic               q_pop,
    input  logic               advance,
    input  logic               div_busy,
    output wasq_pkg::entry_t   entry,
    output wasq_pkg::scale_t   scale
);
    import wasq_pkg::*;

    localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int LEN_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = LEN_W + 1;

    back_state_t state_reg, state_next;

    logic [SAMPLE_W-1:0]        mem [MAX_POINTS];
    logic [MAX_POINTS-1:0]      valid_reg, valid_next;
    logic signed [SAMPLE_W-1:0] clear_val_reg, clear_val_next;
    logic [AW-1:0]              ptr_reg, ptr_next;
    logic [LEN_W-1:0]           idx_reg, idx_next;
    logic [LEN_W-1:0]           n_reg, n_next;
    item_t                      item_reg, item_next;
    logic signed [SAMPLE_W-1:0] lo_reg, lo_next;
    logic signed [SAMPLE_W-1:0] hi_reg, hi_next;
    logic                       first_reg, first_next;
    scale_t                     scale_reg, scale_next;

    logic [SAMPLE_W-1:0]        rdata_reg;
    logic                       rvalid_reg;
    logic                       scan_v_reg;
    logic                       emit_v_reg;
    logic [POS_W-1:0]           epos_reg;
    logic                       elast_reg;

    logic                       rd_en;
    logic                       mem_we;
    logic [LEN_W-1:0]           n_eff;
    logic [LEN_W-1:0]           ptr_ext;
    logic [LEN_W-1:0]           ptr_inc;
    logic [SUM_W-1:0]           phys_sum;
    logic [SUM_W-1:0]           phys;
    logic [AW-1:0]              raddr;
    logic                       idx_last;
    logic signed [SAMPLE_W-1:0] x_res;
    logic signed [SAMPLE_W:0]   span_w;

    // effective window length from the register
    always_comb begin
        if (cfg.window_length == '0) begin
            n_eff = LEN_W'(1);
        end else if (cfg.window_length > LEN_CFG_W'(MAX_POINTS)) begin
            n_eff = LEN_W'(MAX_POINTS);
        end else begin
            n_eff = LEN_W'(cfg.window_length);
        end
    end

    // physical slot of logical index idx_reg
    assign ptr_ext  = LEN_W'(ptr_reg);
    assign ptr_inc  = ptr_ext + LEN_W'(1);
    assign phys_sum = SUM_W'(ptr_ext) + SUM_W'(idx_reg);
    assign phys     = (phys_sum >= SUM_W'(n_reg)) ? phys_sum - SUM_W'(n_reg) : phys_sum;
    assign raddr    = phys[AW-1:0];
    assign idx_last = (idx_reg == n_reg - LEN_W'(1));

    // entry value as read, unwritten slots hold the clear value
    assign x_res  = rvalid_reg ? rdata_reg : clear_val_reg;
    assign span_w = {hi_reg[SAMPLE_W-1], hi_reg} - {lo_reg[SAMPLE_W-1], lo_reg};

    // sequencer next state and outputs
    always_comb begin
        state_next     = state_reg;
        q_pop          = 1'b0;
        rd_en          = 1'b0;
        mem_we         = 1'b0;
        ptr_next       = ptr_reg;
        idx_next       = idx_reg;
        n_next         = n_reg;
        item_next      = item_reg;
        clear_val_next = clear_val_reg;
        valid_next     = valid_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        first_next     = first_reg;
        scale_next     = scale_reg;

        // min/max over the entry read in the previous cycle
        if (scan_v_reg) begin
            first_next = 1'b0;
            if (first_reg) begin
                lo_next = x_res;
                hi_next = x_res;
            end else begin
                if (x_res < lo_reg) lo_next = x_res;
                if (x_res > hi_reg) hi_next = x_res;
            end
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop      = 1'b1;
                    item_next  = q_item;
                    n_next     = n_eff;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (ptr_ext >= n_reg) begin
                    ptr_next = AW'(ptr_ext - n_reg);
                end else begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                idx_next   = '0;
                first_next = 1'b1;
                if (item_reg.action == ACT_CLEAR) begin
                    clear_val_next = cfg.fill_value;
                    valid_next     = '0;
                    ptr_next       = '0;
                end else begin
                    mem_we              = 1'b1;
                    valid_next[ptr_reg] = 1'b1;
                    ptr_next            = (ptr_inc == n_reg) ? '0 : AW'(ptr_inc);
                end
                state_next = ST_SCAN;
            end
            ST_SCAN: begin
                rd_en = 1'b1;
                if (idx_last) begin
                    idx_next   = '0;
                    state_next = ST_SCAN_TAIL;
                end else begin
                    idx_next = idx_reg + LEN_W'(1);
                end
            end
            ST_SCAN_TAIL: begin
                state_next = ST_SETUP;
            end
            ST_SETUP: begin
                scale_next.autoscale = cfg.autoscale_on;
                scale_next.lo        = lo_reg;
                scale_next.zero      = cfg.autoscale_on && (span_w == '0);
                scale_next.divisor   = cfg.autoscale_on ? span_w[SAMPLE_W-1:0] : UNIT_S;
                state_next           = ST_EMIT;
            end
            ST_EMIT: begin
                if (advance) begin
                    rd_en = 1'b1;
                    if (idx_last) begin
                        idx_next   = '0;
                        state_next = ST_DRAIN;
                    end else begin
                        idx_next = idx_reg + LEN_W'(1);
                    end
                end
            end
            ST_DRAIN: begin
                rd_en = advance;
                if (!emit_v_reg && !div_busy) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control and window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ptr_reg       <= '0;
            valid_reg     <= '0;
            clear_val_reg <= '0;
            idx_reg       <= '0;
            n_reg         <= LEN_W'(1);
            first_reg     <= 1'b1;
            scan_v_reg    <= 1'b0;
            emit_v_reg    <= 1'b0;
        end else begin
            ptr_reg       <= ptr_next;
            valid_reg     <= valid_next;
            clear_val_reg <= clear_val_next;
            idx_reg       <= idx_next;
            n_reg         <= n_next;
            first_reg     <= first_next;
            scan_v_reg    <= (state_reg == ST_SCAN);
            if (rd_en) begin
                emit_v_reg <= (state_reg == ST_EMIT);
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg  <= item_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        scale_reg <= scale_next;
    end

    // window store write port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[ptr_reg] <= item_reg.sample;
        end
    end

    // window store read port with its tags
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg  <= mem[raddr];
            rvalid_reg <= valid_reg[raddr];
            epos_reg   <= POS_W'(idx_reg);
            elast_reg  <= idx_last;
        end
    end

    assign entry.valid = emit_v_reg;
    assign entry.x     = x_res;
    assign entry.pos   = epos_reg;
    assign entry.last  = elast_reg;
    assign scale       = scale_reg;

`ifndef SYNTH
    a_ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_UPDATE) |-> (ptr_ext < n_reg))
        else $error("oldest pointer outside window at update");

    a_pop_drained: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> (!div_busy && !emit_v_reg))
        else $error("new item taken while readout still in flight");

    a_slot_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_en && (state_reg == ST_SCAN || state_reg == ST_EMIT) |-> (phys < SUM_W'(n_reg)))
        else $error("read slot outside window");

    a_range_order: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SETUP) |-> (lo_reg <= hi_reg))
        else $error("scan minimum above maximum");
`endif

endmodule

FILE: rtl/core/window_autoscale_quantizer.sv
`timescale 1ns / 1ps
// top level of the window autoscale quantizer
//
//  channel   direction  handshake                fields
//  s_        in         s_tvalid / s_tready      tdata: sample; tuser: action
//  m_        out        m_tvalid / m_tready      tdata: level, position; tlast: last
//  cfg_      in         cfg_wr_en (no wait)      0 autoscale_on, 1 fill_value, 2 window_length
//
//  an item needs, for an effective window length n: n reads of the window store for
//  the min/max scan, n more for the readout at one entry per cycle while the output
//  does not stall, a drain of the divider pipeline, the update, scan-tail and setup
//  states, and a fold of the oldest pointer into a shortened window (one subtract per cycle).
//  reset is synchronous, active low, and clears the store at once through per-entry valid bits.
//  a two-entry queue decouples input from the sequencer; output stalls hold the whole readout.
module window_autoscale_quantizer #(
    parameter int MAX_POINTS = wasq_pkg::DEF_MAX_POINTS
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [wasq_pkg::S_TDATA_W-1:0]    s_tdata,   // [15:0] sample
    input  logic [0:0]                        s_tuser,   // [0] action
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [wasq_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] level, [13:8] position
    output logic                              m_tlast,
    input  logic                              cfg_wr_en,
    input  logic [wasq_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [wasq_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
    import wasq_pkg::*;

    cfg_t   cfg;
    item_t  q_item;
    entry_t entry;
    scale_t scale;
    logic   q_valid;
    logic   q_pop;
    logic   advance;
    logic   div_busy;

    // input side and configuration
    wasq_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    // window store and sequencer
    wasq_back #(
        .MAX_POINTS (MAX_POINTS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .advance   (advance),
        .div_busy  (div_busy),
        .entry     (entry),
        .scale     (scale)
    );

    // level computation and output register
    wasq_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .entry     (entry),
        .scale     (scale),
        .advance   (advance),
        .busy      (div_busy),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

FILE: verif/tb_window_autoscale_quantizer.sv
`timescale 1ns / 1ps
// self-checking testbench of the window autoscale quantizer: directed rows, then random phases
module tb_window_autoscale_quantizer;
    import wasq_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int IDLE_PCT     = 28;
    localparam int SETTLE_CYC   = 16;
    localparam int TAIL_CYC     = 250;
    localparam int RAND_PHASES  = 5;
    localparam int PHASE_ITEMS  = 15;
    localparam int N_ROWS       = 32;
    localparam int LEVEL_TOP    = 255;
    localparam int EXP_DEPTH    = 8192;

    // index with no register behind it, writes there are dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;
    // marks a directed row whose levels come from the predictor only
    localparam logic signed [9:0] ANY_LEVEL = -10'sd1;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_IDX_W-1:0]       idx;
        logic [CFG_DATA_W-1:0]      value;
        logic                       action;
        logic signed [SAMPLE_W-1:0] sample;
        logic signed [9:0]          newest;
    } row_t;

    typedef struct {
        logic [LEVEL_W-1:0] level;
        logic [POS_W-1:0]   pos;
        logic               last;
    } level_exp_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;   // [15:0] sample
    logic [0:0]            s_tuser;   // [0] action
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;   // [7:0] level, [13:8] position
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    // predictor state
    cfg_t                       mirror_cfg;
    logic signed [SAMPLE_W-1:0] mirror_window [DEF_MAX_POINTS];
    int                         mirror_head;
    // expected levels in order, written by the stimulus side and read by the checker
    level_exp_t                 exp_fifo [EXP_DEPTH];
    int                         exp_wr = 0;
    int                         exp_rd = 0;

    logic steady;
    int   cycle_count = 0;
    int   mismatch_count = 0;
    int   updates_sent;
    int   directed_updates;
    int   levels_seen = 0;
    int   reg_writes;
    row_t dir_rows [0:N_ROWS-1];

    window_autoscale_quantizer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always #1 aclk = ~aclk;

    function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        return '{ROW_CFG, idx, value, ACT_ADD, 16'sd0, ANY_LEVEL};
    endfunction

    function automatic row_t item_row(logic action, logic signed [SAMPLE_W-1:0] sample,
                                      logic signed [9:0] newest);
        return '{ROW_ITEM, 2'd0, 16'd0, action, sample, newest};
    endfunction

    // update the mirrored window and queue one level per entry, oldest first
    task automatic quantize_window(input logic action, input logic signed [SAMPLE_W-1:0] sample);
        int n;
        int lo;
        int hi;
        int span;
        int x;
        int lvl;
        level_exp_t rec;
        n = mirror_cfg.window_length;
        if (n < 1) n = 1;
        if (n > DEF_MAX_POINTS) n = DEF_MAX_POINTS;
        mirror_head = mirror_head % n;
        if (action == ACT_CLEAR) begin
            for (int i = 0; i < DEF_MAX_POINTS; i++) mirror_window[i] = mirror_cfg.fill_value;
            mirror_head = 0;
        end else begin
            mirror_window[mirror_head] = sample;
            mirror_head = (mirror_head + 1) % n;
        end
        // min and max over the live entries
        lo = mirror_window[mirror_head];
        hi = lo;
        for (int i = 0; i < n; i++) begin
            x = mirror_window[(mirror_head + i) % n];
            if (x < lo) lo = x;
            if (x > hi) hi = x;
        end
        span = hi - lo;
        for (int i = 0; i < n; i++) begin
            x = mirror_window[(mirror_head + i) % n];
            if (mirror_cfg.autoscale_on) begin
                lvl = (span > 0) ? ((x - lo) * LEVEL_TOP) / span : 0;
            end else begin
                if (x > UNIT_Q) x = UNIT_Q;
                if (x < 0) x = 0;
                lvl = (x * LEVEL_TOP) / UNIT_Q;
            end
            rec.level = lvl[LEVEL_W-1:0];
            rec.pos   = i[POS_W-1:0];
            rec.last  = (i == n - 1);
            exp_fifo[exp_wr % EXP_DEPTH] = rec;
            exp_wr++;
        end
    endtask

    // offer one item, with random idle cycles in front, and predict it once taken
    task automatic send_update(input logic action, input logic signed [SAMPLE_W-1:0] sample,
                               input logic signed [9:0] newest);
        while (!steady && $urandom_range(99) < IDLE_PCT) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= sample;
        s_tuser  <= action;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        quantize_window(action, sample);
        if (newest >= 0) exp_fifo[(exp_wr - 1) % EXP_DEPTH].level = newest[LEVEL_W-1:0];
        updates_sent++;
    endtask

    // let the block run dry before touching a register
    task automatic settle();
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (SETTLE_CYC) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_AUTOSCALE: mirror_cfg.autoscale_on  = value[0];
            REG_FILL:      mirror_cfg.fill_value    = value;
            REG_LENGTH:    mirror_cfg.window_length = value[LEN_CFG_W-1:0];
            default: ;
        endcase
        reg_writes++;
        @(posedge aclk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(3))
            0: begin
                case ($urandom_range(3))
                    0: return 16'sh8000;
                    1: return 16'sh7FFF;
                    2: return 16'sd0;
                    default: return UNIT_S;
                endcase
            end
            1, 2: return SAMPLE_W'($urandom_range(UNIT_Q + 1024) - 512);
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // result side stalls at random except during the steady phase
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
    end

    // compare each level transfer with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            levels_seen++;
            if (exp_wr == exp_rd) begin
                mismatch_count++;
                $display("%0t: expected no level transfer, got level %0d position %0d last %0b",
                         $time, m_tdata[7:0], m_tdata[13:8], m_tlast);
            end else begin
                if (m_tdata[7:0] !== exp_fifo[exp_rd % EXP_DEPTH].level ||
                    m_tdata[13:8] !== exp_fifo[exp_rd % EXP_DEPTH].pos ||
                    m_tlast !== exp_fifo[exp_rd % EXP_DEPTH].last) begin
                    mismatch_count++;
                    $display("%0t: level/position/last expected %0d/%0d/%0b, got %0d/%0d/%0b",
                             $time, exp_fifo[exp_rd % EXP_DEPTH].level,
                             exp_fifo[exp_rd % EXP_DEPTH].pos,
                             exp_fifo[exp_rd % EXP_DEPTH].last,
                             m_tdata[7:0], m_tdata[13:8], m_tlast);
                end
                exp_rd++;
            end
        end
    end

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout with %0d levels still pending", exp_wr - exp_rd);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        logic [CFG_DATA_W-1:0] fill;
        int len;
        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        steady         = 1'b0;
        updates_sent   = 0;
        reg_writes     = 0;
        mirror_cfg     = '{autoscale_on: 1'b0, fill_value: 16'sd0,
                           window_length: LEN_CFG_W'(LEN_RESET)};
        mirror_head    = 0;
        for (int i = 0; i < DEF_MAX_POINTS; i++) mirror_window[i] = '0;

        // directed rows: extremes of clamp and autoscale, clear, length corner cases
        dir_rows = '{
            item_row(ACT_ADD,   UNIT_S,      10'sd255),
            item_row(ACT_ADD,   16'sh8000,   10'sd0),
            item_row(ACT_ADD,   16'sh7FFF,   10'sd255),
            item_row(ACT_ADD,   16'sd0,      10'sd0),
            item_row(ACT_ADD,   16'sd2048,   ANY_LEVEL),
            item_row(ACT_ADD,   16'sd1,      ANY_LEVEL),
            cfg_row(REG_AUTOSCALE, 16'd1),
            item_row(ACT_ADD,   -16'sd1,     ANY_LEVEL),
            item_row(ACT_ADD,   16'sh7FFF,   10'sd255),
            item_row(ACT_ADD,   16'sh8000,   10'sd0),
            item_row(ACT_CLEAR, 16'sd0,      10'sd0),
            cfg_row(REG_FILL,   16'h8000),
            item_row(ACT_CLEAR, 16'sh7FFF,   10'sd0),
            item_row(ACT_ADD,   16'sh7FFF,   10'sd255),
            cfg_row(REG_AUTOSCALE, 16'd0),
            cfg_row(REG_FILL,   16'h7FFF),
            item_row(ACT_CLEAR, 16'sh8000,   10'sd255),
            cfg_row(REG_LENGTH, 16'd1),
            item_row(ACT_ADD,   16'sd1234,   ANY_LEVEL),
            cfg_row(REG_AUTOSCALE, 16'd1),
            item_row(ACT_ADD,   -16'sd5,     10'sd0),
            cfg_row(REG_LENGTH, 16'd0),
            item_row(ACT_ADD,   16'sd100,    10'sd0),
            cfg_row(REG_LENGTH, 16'h007F),
            cfg_row(REG_SPARE,  16'd5),
            item_row(ACT_CLEAR, 16'sd0,      10'sd0),
            item_row(ACT_ADD,   16'sh8000,   10'sd0),
            cfg_row(REG_LENGTH, 16'd5),
            item_row(ACT_ADD,   UNIT_S,      ANY_LEVEL),
            item_row(ACT_ADD,   16'sd3,      ANY_LEVEL),
            cfg_row(REG_LENGTH, 16'd64),
            item_row(ACT_ADD,   16'sd7,      ANY_LEVEL)
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                settle();
                write_reg(dir_rows[r].idx, dir_rows[r].value);
            end else begin
                send_update(dir_rows[r].action, dir_rows[r].sample, dir_rows[r].newest);
            end
        end
        directed_updates = updates_sent;

        // random phases, each with its own register setting
        for (int p = 0; p < RAND_PHASES; p++) begin
            settle();
            steady <= (p == 2);
            case ($urandom_range(4))
                0: fill = 16'h8000;
                1: fill = 16'h7FFF;
                2: fill = 16'h0000;
                3: fill = 16'(UNIT_Q);
                default: fill = 16'($urandom);
            endcase
            case ($urandom_range(19))
                0, 1, 2:    len = DEF_MAX_POINTS;
                3, 4:       len = 0;
                5, 6:       len = 127;
                7, 8, 9:    len = $urandom_range(63, 9);
                default:    len = $urandom_range(8, 1);
            endcase
            if (p == 0) len = 1;
            write_reg(REG_AUTOSCALE, 16'($urandom_range(1)));
            write_reg(REG_FILL, fill);
            write_reg(REG_LENGTH, {9'($urandom), 7'(len)});
            // software normally clears after a length change
            if ($urandom_range(99) < 85) send_update(ACT_CLEAR, pick_sample(), ANY_LEVEL);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                send_update(($urandom_range(99) < 12) ? ACT_CLEAR : ACT_ADD, pick_sample(),
                            ANY_LEVEL);
            end
        end

        // drain, then give the block time to show any extra transfer
        steady <= 1'b0;
        s_tvalid <= 1'b0;
        while (exp_wr != exp_rd) @(posedge aclk);
        repeat (TAIL_CYC) @(posedge aclk);

        $display("updates: %0d (%0d directed), level transfers: %0d, register writes: %0d",
                 updates_sent, directed_updates, levels_seen, reg_writes);
        $display("clamp and autoscale modes, fill extremes, window lengths 0 to 127 covered");
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

FILE: window_autoscale_quantizer.f
rtl/core/wasq_pkg.sv
rtl/core/wasq_front.sv
rtl/core/wasq_div.sv
rtl/core/wasq_back.sv
rtl/core/window_autoscale_quantizer.sv
verif/tb_window_autoscale_quantizer.sv
